/* rtl/gmpt_pkg.sv */
// gmpt_pkg: request codes and field widths shared by the priority table and its checker
`timescale 1ns / 1ps

package gmpt_pkg;

    localparam int REQ_W   = 2;
    localparam int ITEM_W  = 6;
    localparam int GROUP_W = 4;
    localparam int PRIO_W  = 16;

    typedef enum logic [REQ_W-1:0] {
        REQ_LOAD   = 2'd0,
        REQ_CHANGE = 2'd1,
        REQ_QUERY  = 2'd2,
        REQ_NONE   = 2'd3
    } req_type_t;

endpackage

/* rtl/grouped_max_priority_table_unit.sv */
// grouped_max_priority_table_unit: per-group maximum priority table held in one memory
//
//  channel | direction | handshake              | payload
//  in      | input     | in_valid / in_ready    | req_type, item_id, group_id, priority_req
//  out     | output    | out_valid / out_ready  | ok, best_item, best_priority
//
// load and rejected requests skip to S_DONE; change: memory read, then write back
// query: the scan reads one table entry per cycle from the memory
// after reset a clearing pass empties every table entry; in_ready stays low
// the output register holds a result until taken; a new request is accepted meanwhile
// and its result waits in the finishing state while the output register is full
`timescale 1ns / 1ps

module grouped_max_priority_table_unit #(
    parameter int NUM_ITEMS     = 64,
    parameter int NUM_GROUPS    = 16,
    parameter int PRIORITY_BITS = 16
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        in_valid,
    output logic                        in_ready,
    input  logic [gmpt_pkg::REQ_W-1:0]  req_type,
    input  logic [gmpt_pkg::ITEM_W-1:0] item_id,
    input  logic [gmpt_pkg::GROUP_W-1:0] group_id,
    input  logic [gmpt_pkg::PRIO_W-1:0] priority_req,
    output logic                        out_valid,
    input  logic                        out_ready,
    output logic                        ok,
    output logic [gmpt_pkg::ITEM_W-1:0] best_item,
    output logic [gmpt_pkg::PRIO_W-1:0] best_priority
);

    import gmpt_pkg::*;

    localparam int IDX_W = $clog2(NUM_ITEMS);
    localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(NUM_ITEMS - 1);

    typedef struct packed {
        logic                     valid;
        logic [GROUP_W-1:0]       grp;
        logic [PRIORITY_BITS-1:0] prio;
    } entry_t;

    typedef enum logic [2:0] {
        S_CLEAR,
        S_IDLE,
        S_CHANGE,
        S_SCAN,
        S_DONE
    } state_t;

    entry_t mem [NUM_ITEMS];
    entry_t mem_q;

    logic               mem_wr_en;
    logic [IDX_W-1:0]   mem_wr_addr;
    entry_t             mem_wr_data;
    logic               mem_rd_en;
    logic [IDX_W-1:0]   mem_rd_addr;

    state_t                   state_reg, state_next;
    logic [IDX_W-1:0]         idx_reg, idx_next;
    logic [GROUP_W-1:0]       grp_reg, grp_next;
    logic [PRIORITY_BITS-1:0] new_prio_reg, new_prio_next;
    logic                     found_reg, found_next;
    logic [IDX_W-1:0]         best_idx_reg, best_idx_next;
    logic [PRIORITY_BITS-1:0] best_prio_reg, best_prio_next;
    logic                     out_valid_reg, out_valid_next;
    logic                     ok_reg, ok_next;
    logic [ITEM_W-1:0]        best_item_reg, best_item_next;
    logic [PRIO_W-1:0]        best_priority_reg, best_priority_next;

    logic                     accept;
    logic [31:0]              item_ext;
    logic [31:0]              group_ext;
    logic [31:0]              prio_in_ext;
    logic [31:0]              idx_out_ext;
    logic [31:0]              prio_out_ext;
    logic                     item_in_range;
    logic                     group_in_range;
    logic [IDX_W-1:0]         item_idx;
    logic [PRIORITY_BITS-1:0] prio_in;
    logic                     hit;
    logic                     out_free;

    assign in_ready       = (state_reg == S_IDLE);
    assign accept         = in_valid && in_ready;
    assign item_ext       = 32'(item_id);
    assign group_ext      = 32'(group_id);
    assign prio_in_ext    = 32'(priority_req);
    assign item_in_range  = item_ext < 32'(NUM_ITEMS);
    assign group_in_range = group_ext < 32'(NUM_GROUPS);
    assign item_idx       = item_ext[IDX_W-1:0];
    assign prio_in        = prio_in_ext[PRIORITY_BITS-1:0];
    assign idx_out_ext    = 32'(best_idx_reg);
    assign prio_out_ext   = 32'(best_prio_reg);
    assign out_free       = !out_valid_reg || out_ready;
    assign hit            = mem_q.valid && (mem_q.grp == grp_reg)
                            && (!found_reg || (mem_q.prio > best_prio_reg));

    // table memory, one write and one registered read port
    always_ff @(posedge clk)
    begin
        if (mem_wr_en)
        begin
            mem[mem_wr_addr] <= mem_wr_data;
        end
        if (mem_rd_en)
        begin
            mem_q <= mem[mem_rd_addr];
        end
    end

    always_comb
    begin
        state_next         = state_reg;
        idx_next           = idx_reg;
        grp_next           = grp_reg;
        new_prio_next      = new_prio_reg;
        found_next         = found_reg;
        best_idx_next      = best_idx_reg;
        best_prio_next     = best_prio_reg;
        out_valid_next     = out_valid_reg && !out_ready;
        ok_next            = ok_reg;
        best_item_next     = best_item_reg;
        best_priority_next = best_priority_reg;
        mem_wr_en          = 1'b0;
        mem_wr_addr        = idx_reg;
        mem_wr_data        = '0;
        mem_rd_en          = 1'b0;
        mem_rd_addr        = idx_reg;

        case (state_reg)
            S_CLEAR:
            begin
                mem_wr_en   = 1'b1;
                mem_wr_addr = idx_reg;
                idx_next    = idx_reg + IDX_W'(1);
                if (idx_reg == LAST_IDX)
                begin
                    idx_next   = '0;
                    state_next = S_IDLE;
                end
            end
            S_IDLE:
            begin
                if (accept)
                begin
                    found_next     = 1'b0;
                    best_idx_next  = '0;
                    best_prio_next = '0;
                    grp_next       = group_id;
                    new_prio_next  = prio_in;
                    idx_next       = item_idx;
                    state_next     = S_DONE;
                    case (req_type_t'(req_type))
                        REQ_LOAD:
                        begin
                            if (item_in_range && group_in_range)
                            begin
                                mem_wr_en        = 1'b1;
                                mem_wr_addr      = item_idx;
                                mem_wr_data.valid = 1'b1;
                                mem_wr_data.grp  = group_id;
                                mem_wr_data.prio = prio_in;
                                found_next       = 1'b1;
                            end
                        end
                        REQ_CHANGE:
                        begin
                            if (item_in_range)
                            begin
                                mem_rd_en   = 1'b1;
                                mem_rd_addr = item_idx;
                                state_next  = S_CHANGE;
                            end
                        end
                        REQ_QUERY:
                        begin
                            if (group_in_range)
                            begin
                                mem_rd_en   = 1'b1;
                                mem_rd_addr = '0;
                                idx_next    = '0;
                                state_next  = S_SCAN;
                            end
                        end
                        default:
                        begin
                            found_next = 1'b0;
                        end
                    endcase
                end
            end
            S_CHANGE:
            begin
                // read-modify-write of the addressed entry
                if (mem_q.valid)
                begin
                    mem_wr_en        = 1'b1;
                    mem_wr_addr      = idx_reg;
                    mem_wr_data      = mem_q;
                    mem_wr_data.prio = new_prio_reg;
                    found_next       = 1'b1;
                end
                state_next = S_DONE;
            end
            S_SCAN:
            begin
                if (hit)
                begin
                    found_next     = 1'b1;
                    best_idx_next  = idx_reg;
                    best_prio_next = mem_q.prio;
                end
                if (idx_reg == LAST_IDX)
                begin
                    state_next = S_DONE;
                end
                else
                begin
                    mem_rd_en   = 1'b1;
                    mem_rd_addr = idx_reg + IDX_W'(1);
                    idx_next    = idx_reg + IDX_W'(1);
                end
            end
            S_DONE:
            begin
                if (out_free)
                begin
                    out_valid_next     = 1'b1;
                    ok_next            = found_reg;
                    best_item_next     = idx_out_ext[ITEM_W-1:0];
                    best_priority_next = prio_out_ext[PRIO_W-1:0];
                    state_next         = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg         <= S_CLEAR;
            idx_reg           <= '0;
            grp_reg           <= '0;
            new_prio_reg      <= '0;
            found_reg         <= 1'b0;
            best_idx_reg      <= '0;
            best_prio_reg     <= '0;
            out_valid_reg     <= 1'b0;
            ok_reg            <= 1'b0;
            best_item_reg     <= '0;
            best_priority_reg <= '0;
        end
        else
        begin
            state_reg         <= state_next;
            idx_reg           <= idx_next;
            grp_reg           <= grp_next;
            new_prio_reg      <= new_prio_next;
            found_reg         <= found_next;
            best_idx_reg      <= best_idx_next;
            best_prio_reg     <= best_prio_next;
            out_valid_reg     <= out_valid_next;
            ok_reg            <= ok_next;
            best_item_reg     <= best_item_next;
            best_priority_reg <= best_priority_next;
        end
    end

    assign out_valid     = out_valid_reg;
    assign ok            = ok_reg;
    assign best_item     = best_item_reg;
    assign best_priority = best_priority_reg;

endmodule

/* rtl/gmpt_checker.sv */
// gmpt_checker: port-level assertions for the priority table, bound to the table unit
`timescale 1ns / 1ps

module gmpt_checker (
    input logic                         clk,
    input logic                         rst_n,
    input logic                         in_valid,
    input logic                         in_ready,
    input logic [gmpt_pkg::REQ_W-1:0]   req_type,
    input logic                         out_valid,
    input logic                         out_ready,
    input logic                         ok,
    input logic [gmpt_pkg::ITEM_W-1:0]  best_item,
    input logic [gmpt_pkg::PRIO_W-1:0]  best_priority
);

    import gmpt_pkg::*;

    // a failed request or empty query carries a zero payload
    a_fail_zero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !ok |-> (best_item == '0) && (best_priority == '0))
        else $error("failed result with nonzero payload");

    // one request at a time: acceptance closes the input until the result is formed
    a_one_at_a_time: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready |=> !in_ready)
        else $error("input still open after a request");

    // an unused request code is answered, unless the receiver stalls; ok is not checked
    a_none_fails: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready && (req_type == REQ_NONE) |=> ##1 (out_valid && !ok) || !out_ready
            || out_valid)
        else $error("unused request code answered wrongly");

    // a stalled result holds
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(ok) && $stable(best_item)
            && $stable(best_priority))
        else $error("stalled result changed");

endmodule

bind grouped_max_priority_table_unit gmpt_checker u_gmpt_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_valid      (in_valid),
    .in_ready      (in_ready),
    .req_type      (req_type),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .ok            (ok),
    .best_item     (best_item),
    .best_priority (best_priority)
);

/* verif/tb_grouped_max_priority_table_unit.sv */
// testbench for the grouped maximum priority table: directed script, then random requests
`timescale 1ns / 1ps

module tb_grouped_max_priority_table_unit;

    import gmpt_pkg::*;

    localparam int NUM_ITEMS  = 64;
    localparam int NUM_GROUPS = 16;
    localparam int RANDOM_PER_PHASE = 367;
    localparam int SCRIPT_LEN = 25;

    typedef struct packed {
        req_type_t           kind;
        logic [ITEM_W-1:0]   item;
        logic [GROUP_W-1:0]  grp;
        logic [PRIO_W-1:0]   prio;
    } table_request_t;

    typedef struct packed {
        logic                ok;
        logic [ITEM_W-1:0]   best_item;
        logic [PRIO_W-1:0]   best_prio;
    } table_answer_t;

    typedef struct packed {
        req_type_t           kind;
        logic [ITEM_W-1:0]   item;
        logic [GROUP_W-1:0]  grp;
        logic [PRIO_W-1:0]   prio;
        logic                typed;
        logic                exp_ok;
        logic [ITEM_W-1:0]   exp_item;
        logic [PRIO_W-1:0]   exp_prio;
    } script_row_t;

    logic                clk = 1'b0;
    logic                rst_n = 1'b0;
    logic                in_valid = 1'b0;
    logic                in_ready;
    logic [REQ_W-1:0]    req_type = '0;
    logic [ITEM_W-1:0]   item_id = '0;
    logic [GROUP_W-1:0]  group_id = '0;
    logic [PRIO_W-1:0]   priority_req = '0;
    logic                out_valid;
    logic                out_ready = 1'b0;
    logic                ok;
    logic [ITEM_W-1:0]   best_item;
    logic [PRIO_W-1:0]   best_priority;

    // shadow copy of the table
    bit                  tbl_valid [NUM_ITEMS];
    bit [GROUP_W-1:0]    tbl_group [NUM_ITEMS];
    bit [PRIO_W-1:0]     tbl_prio  [NUM_ITEMS];

    table_answer_t       pending_answers [$];

    int sender_idle_pct = 38;
    int recv_stall_pct  = 84;
    int mismatches = 0;
    int n_checked = 0;
    int n_load = 0;
    int n_change = 0;
    int n_change_refused = 0;
    int n_query = 0;
    int n_found = 0;
    int n_none = 0;

    script_row_t script [SCRIPT_LEN] = '{
        '{REQ_QUERY,  6'd0,  4'd0,  16'h0000, 1'b1, 1'b0, 6'd0,  16'h0000},
        '{REQ_QUERY,  6'd0,  4'd15, 16'h0000, 1'b1, 1'b0, 6'd0,  16'h0000},
        '{REQ_CHANGE, 6'd5,  4'd0,  16'h1234, 1'b1, 1'b0, 6'd0,  16'h0000},
        '{REQ_NONE,   6'd63, 4'd15, 16'hffff, 1'b1, 1'b0, 6'd0,  16'h0000},
        '{REQ_LOAD,   6'd0,  4'd0,  16'h0000, 1'b1, 1'b1, 6'd0,  16'h0000},
        '{REQ_LOAD,   6'd63, 4'd15, 16'hffff, 1'b1, 1'b1, 6'd0,  16'h0000},
        '{REQ_QUERY,  6'd0,  4'd15, 16'h0000, 1'b1, 1'b1, 6'd63, 16'hffff},
        '{REQ_QUERY,  6'd63, 4'd0,  16'hffff, 1'b1, 1'b1, 6'd0,  16'h0000},
        '{REQ_LOAD,   6'd10, 4'd0,  16'h0000, 1'b1, 1'b1, 6'd0,  16'h0000},
        '{REQ_QUERY,  6'd0,  4'd0,  16'h0000, 1'b0, 1'b0, 6'd0,  16'h0000},
        '{REQ_CHANGE, 6'd10, 4'd3,  16'h0001, 1'b1, 1'b1, 6'd0,  16'h0000},
        '{REQ_QUERY,  6'd0,  4'd0,  16'h0000, 1'b0, 1'b0, 6'd0,  16'h0000},
        '{REQ_LOAD,   6'd63, 4'd0,  16'hffff, 1'b1, 1'b1, 6'd0,  16'h0000},
        '{REQ_QUERY,  6'd0,  4'd15, 16'h0000, 1'b0, 1'b0, 6'd0,  16'h0000},
        '{REQ_QUERY,  6'd0,  4'd0,  16'h0000, 1'b0, 1'b0, 6'd0,  16'h0000},
        '{REQ_LOAD,   6'd42, 4'd10, 16'haaaa, 1'b1, 1'b1, 6'd0,  16'h0000},
        '{REQ_LOAD,   6'd21, 4'd5,  16'h5555, 1'b1, 1'b1, 6'd0,  16'h0000},
        '{REQ_QUERY,  6'd21, 4'd10, 16'h5555, 1'b0, 1'b0, 6'd0,  16'h0000},
        '{REQ_QUERY,  6'd42, 4'd5,  16'haaaa, 1'b0, 1'b0, 6'd0,  16'h0000},
        '{REQ_CHANGE, 6'd63, 4'd15, 16'h0000, 1'b1, 1'b1, 6'd0,  16'h0000},
        '{REQ_CHANGE, 6'd0,  4'd0,  16'hffff, 1'b1, 1'b1, 6'd0,  16'h0000},
        '{REQ_QUERY,  6'd0,  4'd0,  16'h0000, 1'b0, 1'b0, 6'd0,  16'h0000},
        '{REQ_NONE,   6'd0,  4'd0,  16'h0000, 1'b1, 1'b0, 6'd0,  16'h0000},
        '{REQ_CHANGE, 6'd1,  4'd0,  16'hffff, 1'b1, 1'b0, 6'd0,  16'h0000},
        '{REQ_QUERY,  6'd0,  4'd0,  16'h0000, 1'b0, 1'b0, 6'd0,  16'h0000}
    };

    grouped_max_priority_table_unit #(
        .NUM_ITEMS     (NUM_ITEMS),
        .NUM_GROUPS    (NUM_GROUPS),
        .PRIORITY_BITS (PRIO_W)
    ) dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .in_valid      (in_valid),
        .in_ready      (in_ready),
        .req_type      (req_type),
        .item_id       (item_id),
        .group_id      (group_id),
        .priority_req  (priority_req),
        .out_valid     (out_valid),
        .out_ready     (out_ready),
        .ok            (ok),
        .best_item     (best_item),
        .best_priority (best_priority)
    );

    always #5 clk = ~clk;

    function automatic table_answer_t apply_to_table(input table_request_t r);
        table_answer_t ans;
        ans = '0;
        case (r.kind)
            REQ_LOAD:
            begin
                tbl_valid[r.item] = 1'b1;
                tbl_group[r.item] = r.grp;
                tbl_prio[r.item]  = r.prio;
                ans.ok = 1'b1;
                n_load++;
            end
            REQ_CHANGE:
            begin
                n_change++;
                if (tbl_valid[r.item])
                begin
                    tbl_prio[r.item] = r.prio;
                    ans.ok = 1'b1;
                end
                else
                begin
                    n_change_refused++;
                end
            end
            REQ_QUERY:
            begin
                n_query++;
                for (int i = 0; i < NUM_ITEMS; i++)
                begin
                    if (tbl_valid[i] && tbl_group[i] == r.grp
                        && (!ans.ok || tbl_prio[i] > ans.best_prio))
                    begin
                        ans.ok        = 1'b1;
                        ans.best_item = i[ITEM_W-1:0];
                        ans.best_prio = tbl_prio[i];
                    end
                end
                if (ans.ok)
                begin
                    n_found++;
                end
            end
            default:
            begin
                n_none++;
            end
        endcase
        return ans;
    endfunction

    function automatic int loaded_item(input int fallback);
        int idx;
        for (int t = 0; t < 16; t++)
        begin
            idx = int'($urandom_range(NUM_ITEMS - 1));
            if (tbl_valid[idx])
            begin
                return idx;
            end
        end
        return fallback;
    endfunction

    function automatic table_request_t random_request();
        table_request_t r;
        int roll;
        int idx;
        roll   = int'($urandom_range(99));
        r.kind = REQ_NONE;
        r.item = ITEM_W'($urandom_range(NUM_ITEMS - 1));
        r.grp  = GROUP_W'($urandom_range(NUM_GROUPS - 1));
        r.prio = PRIO_W'($urandom_range(16'hffff));
        // clustered priorities so that ties turn up
        if ($urandom_range(3) == 0)
        begin
            case ($urandom_range(3))
                0: r.prio = 16'h0000;
                1: r.prio = 16'h0001;
                2: r.prio = 16'h8000;
                default: r.prio = 16'hffff;
            endcase
        end
        if (roll < 35)
        begin
            r.kind = REQ_LOAD;
            if ($urandom_range(1) == 0)
            begin
                r.grp = GROUP_W'($urandom_range(3));
            end
        end
        else if (roll < 60)
        begin
            r.kind = REQ_CHANGE;
            if ($urandom_range(3) != 0)
            begin
                r.item = ITEM_W'(loaded_item(int'(r.item)));
            end
        end
        else if (roll < 95)
        begin
            r.kind = REQ_QUERY;
            if ($urandom_range(3) != 0)
            begin
                idx = loaded_item(int'(r.item));
                if (tbl_valid[idx])
                begin
                    r.grp = tbl_group[idx];
                end
            end
        end
        return r;
    endfunction

    task automatic send_request(input table_request_t r, input bit typed,
                                input table_answer_t given);
        table_answer_t predicted;
        while ($urandom_range(99) < sender_idle_pct)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid     <= 1'b1;
        req_type     <= r.kind;
        item_id      <= r.item;
        group_id     <= r.grp;
        priority_req <= r.prio;
        @(posedge clk);
        while (!in_ready)
        begin
            @(posedge clk);
        end
        predicted = apply_to_table(r);
        pending_answers.push_back(typed ? given : predicted);
    endtask

    task automatic check_answer();
        table_answer_t want;
        if (pending_answers.size() == 0)
        begin
            mismatches++;
            if (mismatches <= 10)
            begin
                $display("unexpected answer ok=%0b item=%0d prio=%h at %0t",
                         ok, best_item, best_priority, $realtime);
            end
        end
        else
        begin
            want = pending_answers.pop_front();
            n_checked++;
            if (ok !== want.ok || best_item !== want.best_item
                || best_priority !== want.best_prio)
            begin
                mismatches++;
                if (mismatches <= 10)
                begin
                    $display("answer %0d: expected ok=%0b item=%0d prio=%h,",
                             n_checked, want.ok, want.best_item, want.best_prio,
                             " got ok=%0b item=%0d prio=%h",
                             ok, best_item, best_priority);
                end
            end
        end
    endtask

    always @(posedge clk)
    begin
        if (rst_n && out_valid && out_ready)
        begin
            check_answer();
        end
        out_ready <= ($urandom_range(99) >= recv_stall_pct);
    end

    initial
    begin
        table_request_t r;
        table_answer_t  given;
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;

        for (int n = 0; n < SCRIPT_LEN; n++)
        begin
            r.kind = script[n].kind;
            r.item = script[n].item;
            r.grp  = script[n].grp;
            r.prio = script[n].prio;
            given.ok        = script[n].exp_ok;
            given.best_item = script[n].exp_item;
            given.best_prio = script[n].exp_prio;
            send_request(r, script[n].typed, given);
        end

        for (int phase = 0; phase < 3; phase++)
        begin
            case (phase)
                0:
                begin
                    sender_idle_pct = 38;
                    recv_stall_pct  = 84;
                end
                1:
                begin
                    sender_idle_pct = 84;
                    recv_stall_pct  = 38;
                end
                default:
                begin
                    sender_idle_pct = 0;
                    recv_stall_pct  = 0;
                end
            endcase
            repeat (RANDOM_PER_PHASE)
            begin
                send_request(random_request(), 1'b0, '0);
            end
        end
        in_valid <= 1'b0;

        while (pending_answers.size() != 0)
        begin
            @(posedge clk);
        end
        repeat (NUM_ITEMS + 16) @(posedge clk);

        $display("%0d loads, %0d priority changes (%0d on unloaded items), %0d ignored",
                 n_load, n_change, n_change_refused, n_none);
        $display("%0d group queries, %0d found a maximum; %0d answers checked",
                 n_query, n_found, n_checked);
        if (mismatches == 0)
        begin
            $display("Verification passed");
        end
        else
        begin
            $display("Verification failed");
        end
        $finish;
    end

    initial
    begin
        #10_000_000;
        $display("watchdog expired with %0d answers outstanding", pending_answers.size());
        $display("Verification failed");
        $finish;
    end

endmodule
